// File: sv/mono_framebuffer_rotated_assert.svh
// Assertion macros for the mono_framebuffer_rotated checks.
`ifndef MONO_FRAMEBUFFER_ROTATED_ASSERT_SVH
`define MONO_FRAMEBUFFER_ROTATED_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define MFB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mono_framebuffer_rotated check failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define MFB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mono_framebuffer_rotated check failed");

`endif

// File: sv/mfb_pkg.sv
// Shared constants, codes and controller/datapath types for the frame store.
package mfb_pkg;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 128;

    localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT + 7) / 8;
    localparam int ROW_BYTES   = PANEL_WIDTH / 8;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int PIX_IDX_W   = $clog2(PANEL_WIDTH * PANEL_HEIGHT + 1);

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_DUMP  = 2'd3;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [7:0] CHAR_AT      = 8'h40;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] BIT0_MASK    = 8'h01;

    localparam logic [2:0] OUT_PIXEL = 3'd0;
    localparam logic [2:0] OUT_AT    = 3'd1;
    localparam logic [2:0] OUT_ROW   = 3'd2;
    localparam logic [2:0] OUT_BYTE  = 3'd3;
    localparam logic [2:0] OUT_NL    = 3'd4;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STREAM = 1'b1;

    typedef struct packed {
        logic       capture;
        logic       walk_inc;
        logic       walk_clr;
        logic       clear_wr;
        logic       pix_wr;
        logic       dump_rd;
        logic       out_load;
        logic [2:0] out_sel;
    } mfb_cmd_t;

    typedef struct packed {
        logic is_read;
        logic write_ok;
        logic dump_ok;
        logic walk_store_last;
        logic walk_row_last;
        logic out_free;
    } mfb_status_t;

endpackage

// File: sv/mono_framebuffer_rotated.sv
// Top level: 1-bpp rotated frame store, controller plus datapath around one frame RAM.
// Pixel write: read-modify-write through the registered RAM read port; no new item until done.
// Pixel read: RAM read, then result loaded once the output register is free; next item after.
// Row dump: '@', row, ROW_BYTES frame bytes (each a RAM read), newline; stalls on output.
// Clear: zeros all STORE_BYTES bytes, one byte written per cycle.
// Reset: synchronous; a zeroing pass follows, s_ready low; cfg writes still taken.
module mono_framebuffer_rotated (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_req_type,
    input  logic signed [8:0] s_x_coord,
    input  logic signed [8:0] s_y_coord,
    input  logic              s_pixel_on,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_result_kind,
    output logic              m_pixel_value,
    output logic [7:0]        m_stream_byte,
    output logic              m_last_of_run
);

    mfb_pkg::mfb_cmd_t    cmd;
    mfb_pkg::mfb_status_t status;

    mfb_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .status     (status),
        .cmd        (cmd)
    );

    mfb_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_req_type    (s_req_type),
        .s_x_coord     (s_x_coord),
        .s_y_coord     (s_y_coord),
        .s_pixel_on    (s_pixel_on),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_pixel_value (m_pixel_value),
        .m_stream_byte (m_stream_byte),
        .m_last_of_run (m_last_of_run),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

// File: sv/mfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                                         aclk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/mfb_ctrl.sv
// Controller: sequences clear sweeps, pixel reads, pixel read-modify-write and row dumps.
module mfb_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic [1:0]           s_req_type,
    output logic                 s_ready,
    input  mfb_pkg::mfb_status_t status,
    output mfb_pkg::mfb_cmd_t    cmd
);

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_PIX_WAIT  = 4'd2;
    localparam logic [3:0] S_PIX_DO    = 4'd3;
    localparam logic [3:0] S_DUMP_AT   = 4'd4;
    localparam logic [3:0] S_DUMP_ROW  = 4'd5;
    localparam logic [3:0] S_DUMP_WAIT = 4'd6;
    localparam logic [3:0] S_DUMP_BYTE = 4'd7;
    localparam logic [3:0] S_DUMP_NL   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.out_sel  = mfb_pkg::OUT_PIXEL;
        cmd.capture  = s_valid && s_ready;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (status.walk_store_last) begin
                    cmd.walk_clr = 1'b1;
                    state_next   = S_IDLE;
                end else begin
                    cmd.walk_inc = 1'b1;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    case (s_req_type)
                        mfb_pkg::REQ_WRITE: state_next = S_PIX_WAIT;
                        mfb_pkg::REQ_READ:  state_next = S_PIX_WAIT;
                        mfb_pkg::REQ_CLEAR: state_next = S_CLEAR;
                        mfb_pkg::REQ_DUMP:  state_next = S_DUMP_AT;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_PIX_WAIT: begin
                state_next = S_PIX_DO;
            end
            S_PIX_DO: begin
                if (!status.is_read) begin
                    cmd.pix_wr = status.write_ok;
                    state_next = S_IDLE;
                end else if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = mfb_pkg::OUT_PIXEL;
                    state_next   = S_IDLE;
                end
            end
            S_DUMP_AT: begin
                if (!status.dump_ok) begin
                    state_next = S_IDLE;
                end else if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = mfb_pkg::OUT_AT;
                    state_next   = S_DUMP_ROW;
                end
            end
            S_DUMP_ROW: begin
                cmd.dump_rd = 1'b1;
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = mfb_pkg::OUT_ROW;
                    state_next   = S_DUMP_WAIT;
                end
            end
            S_DUMP_WAIT: begin
                cmd.dump_rd = 1'b1;
                state_next  = S_DUMP_BYTE;
            end
            S_DUMP_BYTE: begin
                cmd.dump_rd = 1'b1;
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = mfb_pkg::OUT_BYTE;
                    if (status.walk_row_last) begin
                        cmd.walk_clr = 1'b1;
                        state_next   = S_DUMP_NL;
                    end else begin
                        cmd.walk_inc = 1'b1;
                        state_next   = S_DUMP_WAIT;
                    end
                end
            end
            S_DUMP_NL: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = mfb_pkg::OUT_NL;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sv/mfb_datapath.sv
// Datapath: rotation register, item capture, address mapping, frame RAM, output register.
module mfb_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_wr_data,
    input  logic [1:0]           s_req_type,
    input  logic signed [8:0]    s_x_coord,
    input  logic signed [8:0]    s_y_coord,
    input  logic                 s_pixel_on,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_result_kind,
    output logic                 m_pixel_value,
    output logic [7:0]           m_stream_byte,
    output logic                 m_last_of_run,
    input  mfb_pkg::mfb_cmd_t    cmd,
    output mfb_pkg::mfb_status_t status
);

    localparam logic [9:0] LIM_W = 10'(mfb_pkg::PANEL_WIDTH);
    localparam logic [9:0] LIM_H = 10'(mfb_pkg::PANEL_HEIGHT);

    logic [1:0]                  rotation_reg, rotation_next;
    logic [1:0]                  req_reg;
    logic signed [8:0]           x_reg, y_reg;
    logic                        on_reg;
    logic [mfb_pkg::ADDR_W-1:0]  walk_reg, walk_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_kind_reg, out_kind_next;
    logic                        out_pix_reg, out_pix_next;
    logic [7:0]                  out_byte_reg, out_byte_next;
    logic                        out_last_reg, out_last_next;

    logic [9:0]                     lim_x, lim_y;
    logic                           x_in_w, y_in_h, x_in_lw, y_in_lh;
    logic                           read_ok;
    logic [7:0]                     px, py;
    logic [mfb_pkg::PIX_IDX_W-1:0]  pix_idx, dump_idx;
    logic [mfb_pkg::ADDR_W-1:0]     pix_addr, dump_addr;
    logic [7:0]                     bit_mask, wr_pixel_data;
    logic                           out_free;
    logic                           ram_we;
    logic [mfb_pkg::ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [7:0]                     ram_wdata, ram_rdata;

    // logical size swaps under quarter turns
    assign lim_x   = rotation_reg[0] ? LIM_H : LIM_W;
    assign lim_y   = rotation_reg[0] ? LIM_W : LIM_H;
    assign x_in_lw = !x_reg[8] && (10'(x_reg[7:0]) < lim_x);
    assign y_in_lh = !y_reg[8] && (10'(y_reg[7:0]) < lim_y);
    assign x_in_w  = !x_reg[8] && (10'(x_reg[7:0]) < LIM_W);
    assign y_in_h  = !y_reg[8] && (10'(y_reg[7:0]) < LIM_H);
    assign read_ok = x_in_w && y_in_h;

    always_comb begin
        px = x_reg[7:0];
        py = y_reg[7:0];
        if (req_reg != mfb_pkg::REQ_READ) begin
            case (rotation_reg)
                mfb_pkg::ROT_90: begin
                    px = 8'(mfb_pkg::PANEL_WIDTH - 1) - y_reg[7:0];
                    py = x_reg[7:0];
                end
                mfb_pkg::ROT_180: begin
                    px = 8'(mfb_pkg::PANEL_WIDTH - 1) - x_reg[7:0];
                    py = 8'(mfb_pkg::PANEL_HEIGHT - 1) - y_reg[7:0];
                end
                mfb_pkg::ROT_270: begin
                    px = y_reg[7:0];
                    py = 8'(mfb_pkg::PANEL_HEIGHT - 1) - x_reg[7:0];
                end
                default: begin
                    px = x_reg[7:0];
                    py = y_reg[7:0];
                end
            endcase
        end
    end

    assign pix_idx = mfb_pkg::PIX_IDX_W'(py) * mfb_pkg::PIX_IDX_W'(mfb_pkg::PANEL_WIDTH)
                   + mfb_pkg::PIX_IDX_W'(px);
    assign pix_addr = mfb_pkg::ADDR_W'(pix_idx >> 3);

    assign dump_idx = mfb_pkg::PIX_IDX_W'(y_reg[7:0]) * mfb_pkg::PIX_IDX_W'(mfb_pkg::ROW_BYTES)
                    + mfb_pkg::PIX_IDX_W'(walk_reg);
    assign dump_addr = mfb_pkg::ADDR_W'(dump_idx);

    assign bit_mask      = mfb_pkg::BIT0_MASK << px[2:0];
    assign wr_pixel_data = on_reg ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);

    assign ram_we    = cmd.clear_wr || cmd.pix_wr;
    assign ram_waddr = cmd.clear_wr ? walk_reg : pix_addr;
    assign ram_wdata = cmd.clear_wr ? 8'h00 : wr_pixel_data;
    assign ram_raddr = cmd.dump_rd ? dump_addr : pix_addr;

    mfb_ram #(
        .WIDTH (8),
        .DEPTH (mfb_pkg::STORE_BYTES)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        rotation_next = cfg_wr_en ? cfg_wr_data : rotation_reg;

        walk_next = walk_reg;
        if (cmd.walk_clr) begin
            walk_next = '0;
        end else if (cmd.walk_inc) begin
            walk_next = walk_reg + 1'b1;
        end

        out_valid_next = out_valid_reg && !m_ready;
        out_kind_next  = out_kind_reg;
        out_pix_next   = out_pix_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
            out_kind_next  = mfb_pkg::KIND_STREAM;
            out_pix_next   = 1'b0;
            out_last_next  = 1'b0;
            case (cmd.out_sel)
                mfb_pkg::OUT_PIXEL: begin
                    out_kind_next = mfb_pkg::KIND_PIXEL;
                    out_pix_next  = read_ok && ram_rdata[px[2:0]];
                    out_byte_next = 8'h00;
                    out_last_next = 1'b1;
                end
                mfb_pkg::OUT_AT:   out_byte_next = mfb_pkg::CHAR_AT;
                mfb_pkg::OUT_ROW:  out_byte_next = y_reg[7:0];
                mfb_pkg::OUT_BYTE: out_byte_next = ram_rdata;
                mfb_pkg::OUT_NL: begin
                    out_byte_next = mfb_pkg::CHAR_NEWLINE;
                    out_last_next = 1'b1;
                end
                default: out_byte_next = 8'h00;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rotation_reg  <= mfb_pkg::ROT_0;
            walk_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            rotation_reg  <= rotation_next;
            walk_reg      <= walk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_req_type;
            x_reg   <= s_x_coord;
            y_reg   <= s_y_coord;
            on_reg  <= s_pixel_on;
        end
        out_kind_reg <= out_kind_next;
        out_pix_reg  <= out_pix_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign status.is_read         = (req_reg == mfb_pkg::REQ_READ);
    assign status.write_ok        = x_in_lw && y_in_lh;
    assign status.dump_ok         = y_in_h;
    assign status.walk_store_last = (walk_reg == mfb_pkg::ADDR_W'(mfb_pkg::STORE_BYTES - 1));
    assign status.walk_row_last   = (walk_reg == mfb_pkg::ADDR_W'(mfb_pkg::ROW_BYTES - 1));
    assign status.out_free        = out_free;

    assign m_valid       = out_valid_reg;
    assign m_result_kind = out_kind_reg;
    assign m_pixel_value = out_pix_reg;
    assign m_stream_byte = out_byte_reg;
    assign m_last_of_run = out_last_reg;

endmodule

// File: sv/mfb_checker.sv
// Port-level checks for the frame store, bound to the top level.
`include "mono_framebuffer_rotated_assert.svh"

module mfb_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic [1:0]        s_req_type,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_result_kind,
    input logic              m_pixel_value,
    input logic [7:0]        m_stream_byte,
    input logic              m_last_of_run
);

    `MFB_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_stream_byte))
    `MFB_ASSERT_NOW(a_read_shape, m_valid && !m_result_kind, m_last_of_run && (m_stream_byte == 8'h00))
    `MFB_ASSERT_NOW(a_dump_shape, m_valid && m_result_kind, !m_pixel_value)
    `MFB_ASSERT_NEXT(a_clear_busy, s_valid && s_ready && (s_req_type == mfb_pkg::REQ_CLEAR), !s_ready)

endmodule

bind mono_framebuffer_rotated mfb_checker u_mfb_checker (.*);
